[design/rgvd_pkg.sv]
// Package for the range-gated voxel downsampler: types, constants, codes.
`default_nettype none
package rgvd_pkg;

  localparam int unsigned NumBuckets = 1024;
  localparam int unsigned NumWays    = 4;
  localparam int unsigned BucketW    = $clog2(NumBuckets);
  localparam int unsigned WayW       = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int unsigned CoordW     = 24;
  localparam int unsigned KeyW       = 21;
  localparam int unsigned VoxKeyW    = 3 * KeyW;
  localparam int unsigned DivW       = 16;
  localparam int unsigned EpochW     = 8;
  localparam logic [31:0] HashGolden = 32'h9e37_79b9;

  localparam logic [1:0] CfgMinRange  = 2'd0;
  localparam logic [1:0] CfgMaxRange  = 2'd1;
  localparam logic [1:0] CfgVoxelSize = 2'd2;

  typedef struct packed {
    logic                     first_of_cloud;
    logic                     is_finite;
    logic signed [CoordW-1:0] x_mm;
    logic signed [CoordW-1:0] y_mm;
    logic signed [CoordW-1:0] z_mm;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x_mm;
    logic signed [CoordW-1:0] out_y_mm;
    logic signed [CoordW-1:0] out_z_mm;
    logic                     bucket_full;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQ,
    ST_RANGE,
    ST_DIV,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear_step;
    logic sq_step;
    logic div_start;
    logic div_step;
    logic hash_step;
    logic rd_step;
    logic cmp_step;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic sq_done;
    logic in_range;
    logic div_done;
    logic hash_done;
    logic rd_done;
    logic hit;
    logic sweep_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

[design/rgvd_ctrl.sv]
// Controller state machine for the voxel downsampler.
`default_nettype none
module rgvd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             first_i,
  input  wire logic             finite_i,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rgvd_pkg::dp_cmd_t     cmd_o,
  input  wire rgvd_pkg::dp_sts_t sts_i
);
  import rgvd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready    = 1'b0;
    out_valid_d = out_valid_q && !out_ready;
    case (state_q)
      ST_IDLE: begin
        // key memory sweep after reset holds off new points
        in_ready = !sts_i.sweep_busy;
        if (in_valid && in_ready) begin
          cmd_o.load = 1'b1;
          if (first_i)       state_d = ST_CLEAR;
          else if (finite_i) state_d = ST_SQ;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = finite_i ? ST_SQ : ST_IDLE;
      end
      ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_done) state_d = ST_RANGE;
      end
      ST_RANGE: begin
        cmd_o.div_start = 1'b1;
        state_d = sts_i.in_range ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_HASH;
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_done) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_step = 1'b1;
        if (sts_i.rd_done) state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp_step = 1'b1;
        state_d = sts_i.hit ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        // wait for output register to drain
        if (!out_valid_q || out_ready) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/rgvd_datapath.sv]
// Datapath: range check, serial dividers, hash, key memory and output register.
`default_nettype none
module rgvd_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire rgvd_pkg::in_item_t in_i,
  input  wire rgvd_pkg::dp_cmd_t  cmd_i,
  output rgvd_pkg::dp_sts_t       sts_o,
  output rgvd_pkg::out_item_t     out_o
);
  import rgvd_pkg::*;

  localparam int unsigned Entries = NumBuckets * NumWays;
  localparam int unsigned EntW    = $clog2(Entries);
  localparam int unsigned MagW    = CoordW;
  localparam int unsigned SqW     = 2 * CoordW + 2;

  // config
  logic [22:0] min_q, max_q;
  logic [15:0] vsz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 23'd0;
      max_q <= 23'd100000;
      vsz_q <= 16'd250;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgMinRange:  min_q <= cfg_data[22:0];
        CfgMaxRange:  max_q <= cfg_data[22:0];
        CfgVoxelSize: vsz_q <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured point
  logic signed [CoordW-1:0] c_q [3];
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q[0] <= in_i.x_mm;
      c_q[1] <= in_i.y_mm;
      c_q[2] <= in_i.z_mm;
    end
  end

  // squares: one multiply per cycle, x y z then min then max
  logic [2:0]       sq_cnt_q;
  logic [SqW-1:0]   r2_q;
  logic [47:0]      prod_q;
  logic [45:0]      min2_q;
  logic [45:0]      max2_q;
  logic [MagW-1:0]  mag_a;
  logic [MagW-1:0]  mag_sel;
  always_comb begin
    case (sq_cnt_q)
      3'd0: mag_sel = c_q[0][CoordW-1] ? -c_q[0] : c_q[0];
      3'd1: mag_sel = c_q[1][CoordW-1] ? -c_q[1] : c_q[1];
      3'd2: mag_sel = c_q[2][CoordW-1] ? -c_q[2] : c_q[2];
      3'd3: mag_sel = {1'b0, min_q};
      default: mag_sel = {1'b0, max_q};
    endcase
  end
  assign mag_a = mag_sel;
  logic [47:0] sq_full;
  assign sq_full = mag_a * mag_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_cnt_q <= '0;
    else if (cmd_i.load) sq_cnt_q <= '0;
    else if (cmd_i.sq_step && sq_cnt_q != 3'd5) sq_cnt_q <= sq_cnt_q + 3'd1;
  end
  // product registered, accumulated the next cycle
  logic [2:0] acc_idx_q;
  logic       acc_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.sq_step && sq_cnt_q != 3'd5;
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q    <= sq_full;
    acc_idx_q <= sq_cnt_q;
    if (cmd_i.load) r2_q <= '0;
    else if (acc_v_q) begin
      case (acc_idx_q)
        3'd3:    min2_q <= prod_q[45:0];
        3'd4:    max2_q <= prod_q[45:0];
        default: r2_q   <= r2_q + SqW'(prod_q);
      endcase
    end
  end
  assign sts_o.sq_done  = (sq_cnt_q == 3'd5) && !acc_v_q;
  assign sts_o.in_range = (r2_q >= SqW'(min2_q)) && (r2_q <= SqW'(max2_q));

  // restoring divider, one quotient bit per cycle, three axes in parallel
  logic [DivW-1:0]   dvs_q;
  logic [MagW-1:0]   quo_q [3];
  logic [DivW:0]     rem_q [3];
  logic [$clog2(MagW+1)-1:0] div_cnt_q;
  logic signed [KeyW-1:0] k_q [3];
  logic              fix_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvs_q     <= (vsz_q < 16'd8) ? 16'd8 : vsz_q;
      div_cnt_q <= '0;
      fix_q     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        quo_q[i] <= c_q[i][CoordW-1] ? -c_q[i] : c_q[i];
        rem_q[i] <= '0;
      end
    end else if (cmd_i.div_step && !fix_q) begin
      if (div_cnt_q == ($clog2(MagW+1))'(MagW)) begin
        fix_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          // floor for negative: -(q) - (rem != 0)
          if (c_q[i][CoordW-1])
            k_q[i] <= KeyW'(-quo_q[i] - MagW'(rem_q[i] != '0));
          else
            k_q[i] <= KeyW'(quo_q[i]);
        end
      end else begin
        div_cnt_q <= div_cnt_q + 1'b1;
        for (int i = 0; i < 3; i++) begin
          logic [DivW:0] tr;
          tr = {rem_q[i][DivW-1:0], quo_q[i][MagW-1]};
          if (tr >= {1'b0, dvs_q}) begin
            rem_q[i] <= tr - {1'b0, dvs_q};
            quo_q[i] <= {quo_q[i][MagW-2:0], 1'b1};
          end else begin
            rem_q[i] <= tr;
            quo_q[i] <= {quo_q[i][MagW-2:0], 1'b0};
          end
        end
      end
    end
  end
  assign sts_o.div_done = fix_q;

  // hash, one axis per cycle
  logic [1:0]  h_cnt_q;
  logic [31:0] seed_q;
  logic [31:0] kx32;
  always_comb begin
    case (h_cnt_q)
      2'd0:    kx32 = 32'(k_q[0]);
      2'd1:    kx32 = 32'(k_q[1]);
      default: kx32 = 32'(k_q[2]);
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      h_cnt_q <= '0;
      seed_q  <= '0;
    end else if (cmd_i.hash_step && h_cnt_q != 2'd3) begin
      seed_q  <= seed_q ^ (kx32 + HashGolden + (seed_q << 6) + (seed_q >> 2));
      h_cnt_q <= h_cnt_q + 2'd1;
    end
  end
  assign sts_o.hash_done = (h_cnt_q == 2'd3);

  logic [BucketW-1:0] bkt;
  assign bkt = seed_q[BucketW-1:0];
  logic [VoxKeyW-1:0] key;
  assign key = {k_q[2], k_q[1], k_q[0]};

  // key memory with epoch tags: an entry is valid when its tag matches the
  // current epoch; the epoch wrap triggers a sweep of the tag memory
  logic [VoxKeyW+EpochW-1:0] mem [Entries];
  logic [EpochW-1:0]         epoch_q;
  logic                      sweep_q;
  logic [EntW-1:0]           sw_addr_q;
  logic                      clr_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q   <= EpochW'(1);
      sweep_q   <= 1'b1;
      sw_addr_q <= '0;
    end else if (cmd_i.clear_step && !sweep_q) begin
      epoch_q <= epoch_q + 1'b1;
      if (epoch_q == {EpochW{1'b1}}) begin
        sweep_q <= 1'b1;
      end
    end else if (sweep_q) begin
      sw_addr_q <= sw_addr_q + 1'b1;
      if (sw_addr_q == EntW'(Entries - 1)) sweep_q <= 1'b0;
    end
  end
  assign clr_done = cmd_i.clear_step && !sweep_q && epoch_q != {EpochW{1'b1}};
  // epoch 0 is never live: live epochs run 1..max, sweep writes 0
  assign sts_o.clear_done = clr_done;
  assign sts_o.sweep_busy = sweep_q;

  // way read, one way per cycle
  logic [WayW:0]            rw_q;
  logic [VoxKeyW+EpochW-1:0] rd_q;
  logic                     rd_v_q;
  logic [WayW:0]            rd_way_q;
  logic                     hit_q;
  logic                     free_v_q;
  logic [WayW-1:0]          free_w_q;
  logic [EntW-1:0]          rd_addr;
  assign rd_addr = EntW'({bkt, rw_q[WayW-1:0]} & {EntW{1'b1}});

  logic                     wr_en;
  logic [EntW-1:0]          wr_addr;
  logic [VoxKeyW+EpochW-1:0] wr_data;
  always_comb begin
    wr_en   = sweep_q || (cmd_i.commit && free_v_q);
    wr_addr = sweep_q ? sw_addr_q : EntW'({bkt, free_w_q});
    wr_data = sweep_q ? '0 : {epoch_q, key};
  end
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  logic rd_issue;
  assign rd_issue = cmd_i.rd_step && rw_q != (WayW+1)'(NumWays);
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_step) begin
      rw_q     <= '0;
      rd_v_q   <= 1'b0;
      hit_q    <= 1'b0;
      free_v_q <= 1'b0;
    end else if (cmd_i.rd_step || cmd_i.cmp_step) begin
      if (rd_issue) rw_q <= rw_q + 1'b1;
      rd_v_q   <= rd_issue;
      rd_way_q <= rw_q;
      if (rd_v_q) begin
        if (rd_q[VoxKeyW +: EpochW] == epoch_q) begin
          if (rd_q[VoxKeyW-1:0] == key) hit_q <= 1'b1;
        end else if (!free_v_q) begin
          free_v_q <= 1'b1;
          free_w_q <= rd_way_q[WayW-1:0];
        end
      end
    end
  end
  assign sts_o.rd_done = (rw_q == (WayW+1)'(NumWays)) && !rd_v_q;
  assign sts_o.hit     = hit_q;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_o.out_x_mm    <= c_q[0];
      out_o.out_y_mm    <= c_q[1];
      out_o.out_z_mm    <= c_q[2];
      out_o.bucket_full <= !free_v_q;
    end
  end
endmodule
`default_nettype wire

[design/range_gated_voxel_downsample.sv]
// Top level of the range-gated voxel downsampler.
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     rgvd_pkg::in_item_t
//  out      output     out_valid / out_ready   rgvd_pkg::out_item_t
//  cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
// One point at a time; a kept point passes from its transaction to the commit through
// accept, squares, range, serial divide (24 quotient bits), hash, four-way sequential
// read, compare and emit; a first-of-cloud point adds a clear step. Dropped points
// leave early: non-finite at accept, out of range after the range check, already
// recorded after the compare. After reset a sweep zeroes all 4096 key memory entries
// and input waits for it; it repeats every 255 clouds, holding a first-of-cloud point.
// The result sits in an output register; the next point is taken meanwhile.
`default_nettype none
module range_gated_voxel_downsample (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rgvd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rgvd_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import rgvd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    first_q, finite_q;

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      first_q  <= in_data.first_of_cloud;
      finite_q <= in_data.is_finite;
    end
  end

  assign cfg_ready = 1'b1;

  rgvd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .first_i  (in_ready ? in_data.first_of_cloud : first_q),
    .finite_i (in_ready ? in_data.is_finite : finite_q),
    .out_valid, .out_ready,
    .cmd_o (cmd), .sts_i (sts)
  );

  rgvd_datapath u_dp (
    .clk_i, .rst_ni, .cfg_valid, .cfg_index, .cfg_data,
    .in_i (in_data), .cmd_i (cmd), .sts_o (sts), .out_o (out_data)
  );

`ifndef SYNTHESIS
  a_no_commit_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid || out_ready)) else $error("output overrun");
  a_load_only_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid && in_ready)) else $error("load without transaction");
  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire
